// ===== src/fasta_batch_parser_top_defines.svh =====
// Assertion macros shared by the FASTA batch parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FASTA_BATCH_PARSER_TOP_DEFINES_SVH
`define FASTA_BATCH_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define FBP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fbp assertion failed");

// next-cycle implication
`define FBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fbp assertion failed");

`endif

// ===== src/fbp_pkg.sv =====
// Package for the FASTA batch parser: payload structs, codes and limits.
// No dependencies.
`timescale 1ns / 1ps
package fbp_pkg;

  localparam int unsigned MAX_RECORDS = 64;
  localparam int unsigned MAX_LEN     = 4096;
  localparam int unsigned ID_LEN      = 128;

  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;
  localparam logic [1:0] ACT_BATCH = 2'd2;

  localparam logic [2:0] KIND_CONSUMED = 3'd0;
  localparam logic [2:0] KIND_SEQ_CHAR = 3'd1;
  localparam logic [2:0] KIND_ID_CHAR  = 3'd2;
  localparam logic [2:0] KIND_ID_END   = 3'd3;
  localparam logic [2:0] KIND_CLOSED   = 3'd4;
  localparam logic [2:0] KIND_REFUSED  = 3'd5;
  localparam logic [2:0] KIND_DROPPED  = 3'd6;

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
  } fbp_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  record_index;
    logic [11:0] position;
    logic [7:0]  out_symbol;
    logic [17:0] buffer_address;
    logic [12:0] record_length;
    logic [12:0] longest_length;
    logic [6:0]  batch_count;
    logic        batch_full;
  } fbp_out_t;

endpackage

// ===== src/fasta_batch_parser_top.sv =====
// Top level of the FASTA batch parser: input register, width register, output register.
// Depends on fbp_pkg, fbp_core and fasta_batch_parser_top_defines.svh.
//
//   port group   dir   handshake             payload
//   in_*         in    in_valid_i/in_stall_o  fbp_in_t  (action, symbol)
//   out_*        out   out_valid_o/out_stall_i fbp_out_t (kind .. batch_full)
//   cfg_*        in    cfg_we_i               cfg_wdata_i (batch_width)
//
// One transfer in and one result out per cycle while the output is not stalled;
// each item passes the input register, then is decoded into the output register.
// Reset clears the parser state, both valid flags and sets batch_width to 64.
// An output stall holds the result and backs up into the input register;
// the input stalls only while that register holds an item that cannot move.
`timescale 1ns / 1ps
`include "fasta_batch_parser_top_defines.svh"

module fasta_batch_parser_top
  import fbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  fbp_in_t    in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output fbp_out_t   out_item_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  logic       in_valid_q;
  fbp_in_t    in_item_q;
  logic       out_valid_q;
  fbp_out_t   out_item_q;
  logic [6:0] width_q;
  logic       step;
  logic       in_take;
  fbp_out_t   result;

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  fbp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .width_cfg_i (width_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 7'(MAX_RECORDS);
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_item_q <= in_item_i;
    if (step) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `FBP_ASSERT_NOW(a_stall_needs_item, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q)
  `FBP_ASSERT_NOW(a_close_le_longest, clk_i, rst_ni,
                  out_valid_q && out_item_q.kind == KIND_CLOSED,
                  out_item_q.record_length <= out_item_q.longest_length)
  `FBP_ASSERT_NEXT(a_step_fills_out, clk_i, rst_ni, step, out_valid_q)

endmodule

// ===== src/fbp_core.sv =====
// Parser state and per-byte decode for the FASTA batch parser.
// Depends on fbp_pkg and fasta_batch_parser_top_defines.svh.
`timescale 1ns / 1ps
`include "fasta_batch_parser_top_defines.svh"

module fbp_core
  import fbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  fbp_in_t    item_i,
  input  logic [6:0] width_cfg_i,
  output fbp_out_t   result_o
);

  localparam logic [1:0] ST_START  = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_ID     = 2'd2;
  localparam logic [1:0] ST_SEQ    = 2'd3;

  localparam logic [6:0]  WMAX   = 7'(MAX_RECORDS);
  localparam logic [12:0] LENMAX = 13'(MAX_LEN);
  localparam logic [6:0]  IDMAX  = 7'(ID_LEN - 1);

  logic [1:0]  state_q, state_d;
  logic [12:0] seq_pos_q, seq_pos_d;
  logic [6:0]  id_pos_q, id_pos_d;
  logic [6:0]  rec_cnt_q, rec_cnt_d;
  logic [12:0] longest_q, longest_d;

  logic [6:0]  width;
  logic [18:0] seq_prod;
  logic [17:0] seq_addr;
  logic [17:0] id_addr;
  fbp_out_t    res;

  always_comb begin
    if (width_cfg_i == 7'd0) begin
      width = 7'd1;
    end else if (width_cfg_i > WMAX) begin
      width = WMAX;
    end else begin
      width = width_cfg_i;
    end
  end

  assign seq_prod = 19'(width) * 19'(seq_pos_q[11:0]);
  assign seq_addr = 18'(seq_prod + 19'(rec_cnt_q));
  assign id_addr  = 18'({rec_cnt_q, id_pos_q});

  always_comb begin
    state_d   = state_q;
    seq_pos_d = seq_pos_q;
    id_pos_d  = id_pos_q;
    rec_cnt_d = rec_cnt_q;
    longest_d = longest_q;
    res       = '0;
    res.kind  = KIND_CONSUMED;

    if (item_i.action == ACT_DATA || item_i.action == ACT_END) begin
      if (rec_cnt_q >= width) begin
        res.kind = KIND_REFUSED;
      end else if (item_i.action == ACT_END) begin
        if (state_q == ST_SEQ && seq_pos_q != 13'd0) begin
          res.kind          = KIND_CLOSED;
          res.record_index  = rec_cnt_q[5:0];
          res.record_length = seq_pos_q;
          if (seq_pos_q > longest_q) longest_d = seq_pos_q;
          rec_cnt_d = rec_cnt_q + 7'd1;
        end
        state_d   = ST_START;
        seq_pos_d = '0;
        id_pos_d  = '0;
      end else begin
        unique case (state_q)
          ST_START: begin
            if (item_i.symbol == CH_GT) state_d = ST_ID;
          end
          ST_HEADER: begin
            if (item_i.symbol == CH_NL) state_d = ST_SEQ;
          end
          ST_ID: begin
            if (item_i.symbol == CH_NL || item_i.symbol == CH_SP) begin
              res.kind           = KIND_ID_END;
              res.record_index   = rec_cnt_q[5:0];
              res.position       = 12'(id_pos_q);
              res.buffer_address = id_addr;
              id_pos_d           = '0;
              state_d            = (item_i.symbol == CH_NL) ? ST_SEQ : ST_HEADER;
            end else if (id_pos_q < IDMAX) begin
              res.kind           = KIND_ID_CHAR;
              res.record_index   = rec_cnt_q[5:0];
              res.position       = 12'(id_pos_q);
              res.out_symbol     = item_i.symbol;
              res.buffer_address = id_addr;
              id_pos_d           = id_pos_q + 7'd1;
            end
          end
          ST_SEQ: begin
            if (item_i.symbol == CH_GT) begin
              res.kind          = KIND_CLOSED;
              res.record_index  = rec_cnt_q[5:0];
              res.record_length = seq_pos_q;
              if (seq_pos_q > longest_q) longest_d = seq_pos_q;
              rec_cnt_d = rec_cnt_q + 7'd1;
              seq_pos_d = '0;
              state_d   = ST_ID;
              id_pos_d  = '0;
            end else if (item_i.symbol == CH_NL) begin
              // line break inside sequence: skipped
            end else if (seq_pos_q < LENMAX) begin
              res.kind           = KIND_SEQ_CHAR;
              res.record_index   = rec_cnt_q[5:0];
              res.position       = seq_pos_q[11:0];
              res.out_symbol     = item_i.symbol;
              res.buffer_address = seq_addr;
              seq_pos_d          = seq_pos_q + 13'd1;
            end else begin
              res.kind         = KIND_DROPPED;
              res.record_index = rec_cnt_q[5:0];
              res.out_symbol   = item_i.symbol;
            end
          end
          default: begin
            state_d = ST_START;
          end
        endcase
      end
    end else if (item_i.action == ACT_BATCH) begin
      rec_cnt_d = '0;
      longest_d = '0;
      seq_pos_d = '0;
      id_pos_d  = '0;
    end

    res.longest_length = longest_d;
    res.batch_count    = rec_cnt_d;
    res.batch_full     = (rec_cnt_d == width);
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_START;
      seq_pos_q <= '0;
      id_pos_q  <= '0;
      rec_cnt_q <= '0;
      longest_q <= '0;
    end else if (step_i) begin
      state_q   <= state_d;
      seq_pos_q <= seq_pos_d;
      id_pos_q  <= id_pos_d;
      rec_cnt_q <= rec_cnt_d;
      longest_q <= longest_d;
    end
  end

  `FBP_ASSERT_NOW(a_seq_pos_bound, clk_i, rst_ni, 1'b1, seq_pos_q <= LENMAX)
  `FBP_ASSERT_NOW(a_id_pos_bound, clk_i, rst_ni, 1'b1, id_pos_q <= IDMAX)
  `FBP_ASSERT_NOW(a_longest_bound, clk_i, rst_ni, 1'b1, longest_q <= LENMAX)

endmodule
